>>> rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 8;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic read_needed;
  } stat_t;

endpackage

>>> rtl/deq_if.sv
// request and response channel interfaces
interface deq_req_if;
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::OPCODE_W-1:0]   opcode;
  logic [deq_pkg::BYTE_W-1:0]     push_data;

  modport source (output valid, opcode, push_data, input ready);
  modport sink (input valid, opcode, push_data, output ready);
endinterface

interface deq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::BYTE_W-1:0]     out_data;
  logic [deq_pkg::STATUS_W-1:0]   status;
  logic [deq_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, out_data, status, entry_count, input ready);
  modport sink (input valid, out_data, status, entry_count, output ready);
endinterface

>>> rtl/deq_ctrl.sv
// controller state machine for the double-ended queue
module deq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  deq_pkg::stat_t  stat,
  output deq_pkg::cmd_t   cmd
);

  deq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.respond = 1'b0;
    unique case (state)
      deq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = stat.read_needed ? deq_pkg::S_READ : deq_pkg::S_IDLE;
        end
      end
      deq_pkg::S_READ: begin
        cmd.respond = 1'b1;
        state_next  = deq_pkg::S_IDLE;
      end
      default: state_next = deq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/deq_dpath.sv
// datapath: entry memory, pointers, fill count and result register
module deq_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::cmd_t                   cmd,
  output deq_pkg::stat_t                  stat,
  input  logic [deq_pkg::OPCODE_W-1:0]    opcode,
  input  logic [deq_pkg::BYTE_W-1:0]      push_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [deq_pkg::BYTE_W-1:0]      out_data,
  output logic [deq_pkg::STATUS_W-1:0]    status,
  output logic [deq_pkg::COUNT_W-1:0]     entry_count
);

  localparam logic [deq_pkg::PTR_W-1:0] LAST_SLOT = deq_pkg::PTR_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT  = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_WIDTH-1:0] rd_data;

  logic [deq_pkg::OPCODE_W-1:0]   op_q;
  logic [deq_pkg::DATA_WIDTH-1:0] data_q;

  logic [deq_pkg::PTR_W-1:0] front, front_next;
  logic [deq_pkg::PTR_W-1:0] back, back_next;
  logic [deq_pkg::CNT_W-1:0] count, count_next;

  logic [deq_pkg::PTR_W-1:0] front_prev, front_inc, back_prev, back_inc;
  logic [deq_pkg::PTR_W-1:0] wr_addr, rd_addr;
  logic                      wr_en, rd_en;
  logic                      is_empty, is_full;
  deq_pkg::status_t          res_status;
  logic [deq_pkg::STATUS_W-1:0] res_status_q;
  logic [deq_pkg::CNT_W-1:0] res_count_q;

  assign is_empty   = (count == '0);
  assign is_full    = (count == FULL_CNT);
  assign front_prev = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc  = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign back_prev  = (back == '0) ? LAST_SLOT : back - 1'b1;
  assign back_inc   = (back == LAST_SLOT) ? '0 : back + 1'b1;

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = back;
    rd_addr    = front;
    res_status = deq_pkg::ST_OK;
    stat.out_free    = !out_valid || out_ready;
    stat.read_needed = 1'b0;
    case (op_q)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          res_status = deq_pkg::ST_FULL;
        end else begin
          front_next = front_prev;
          wr_addr    = front_prev;
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          res_status = deq_pkg::ST_FULL;
        end else begin
          back_next  = back_inc;
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          res_status = deq_pkg::ST_EMPTY;
        end else begin
          stat.read_needed = 1'b1;
          if (op_q == deq_pkg::OP_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
        rd_addr = back_prev;
        if (is_empty) begin
          res_status = deq_pkg::ST_EMPTY;
        end else begin
          stat.read_needed = 1'b1;
          if (op_q == deq_pkg::OP_POP_BACK) begin
            back_next  = back_prev;
            count_next = count - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_en = cmd.execute && stat.read_needed;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      data_q <= deq_pkg::DATA_WIDTH'(push_data);
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[wr_addr] <= data_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status_q <= res_status;
      res_count_q  <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.execute && !stat.read_needed) || cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && !stat.read_needed) begin
      out_data    <= '0;
      status      <= res_status;
      entry_count <= deq_pkg::COUNT_W'(count_next);
    end else if (cmd.respond) begin
      out_data    <= deq_pkg::BYTE_W'(rd_data);
      status      <= res_status_q;
      entry_count <= deq_pkg::COUNT_W'(res_count_q);
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
// top level of the double-ended queue
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   opcode, push_data
//   rsp      out  valid/ready   out_data, status, entry_count
//
// an operation goes from transfer via the captured request to the result register
// (push, error, unused code), or also via the registered read port of the entry
// memory (pop, peek); a new request is taken only in idle, after the last one is done.
// rst is synchronous; it empties the queue and drops any pending result.
// a stalled response holds the next operation in its execute state.
module double_ended_queue (
  input  logic            clk,
  input  logic            rst,
  deq_req_if.sink         req,
  deq_rsp_if.source       rsp
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (req.opcode),
    .push_data   (req.push_data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_data    (rsp.out_data),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

  a_respond_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> $past(cmd.execute))
    else $error("memory response without a preceding execute");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.entry_count <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == deq_pkg::ST_FULL
      |-> rsp.entry_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH))
    else $error("full status with queue not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == deq_pkg::ST_EMPTY
      |-> rsp.entry_count == '0 && rsp.out_data == '0)
    else $error("empty status with nonzero data or count");

  a_no_exec_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !rsp.valid || rsp.ready)
    else $error("execute while the result register is held");

endmodule
